// File: rtl/wpf_pkg.sv
`timescale 1ns / 1ps
package wpf_pkg;

  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);

  localparam int unsigned POS_W   = 24;
  localparam int unsigned VEL_W   = 25;
  localparam int unsigned TGT_W   = 5;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned MAG_W   = POS_W + 1;
  localparam int unsigned RAD_W   = 2 * MAG_W;
  localparam int unsigned ROOT_W  = MAG_W;
  localparam int unsigned Q_W     = VEL_W;
  localparam int unsigned NUM_W   = MAG_W + SPEED_W + FRAC_BITS;
  localparam int unsigned MUL_W   = 26;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned STEPS   = ROOT_W;
  localparam int unsigned STEP_W  = $clog2(STEPS);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic REG_SPEED = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [SPEED_W-1:0] SPEED_RST = 16'd100;
  localparam logic [TGT_W-1:0]   COUNT_RST = 5'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD, OP_RD_ZERO, OP_START, OP_FINISH,
    OP_RD_PREV, OP_RD_TGT, OP_DIR, OP_SQX, OP_SQY, OP_SQSUM, OP_SQRT_STEP,
    OP_NUMX, OP_NUMY, OP_DIVSET, OP_DIV_STEP, OP_VEL, OP_DISPX, OP_DISPY,
    OP_DOTX, OP_DOTY, OP_UPDATE, OP_PUBLISH
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_START_RD, S_START_SET, S_TK_PREV, S_TK_TGT, S_TK_DIR,
    S_SQX, S_SQY, S_SQSUM, S_SQRT, S_NUMX, S_NUMY, S_DIVSET, S_DIV, S_VEL,
    S_DISPX, S_DISPY, S_DOTX, S_DOTY, S_UPD, S_PUB
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       done;
    logic       tgt_bad;
  } status_t;

endpackage

// File: rtl/wpf_in_if.sv
`timescale 1ns / 1ps
interface wpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  point_index;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic [15:0] time_step;

  modport source (output valid, mode, point_index, point_x, point_y, time_step,
                  input ready);
  modport sink (input valid, mode, point_index, point_x, point_y, time_step,
                output ready);
endinterface

// File: rtl/wpf_out_if.sv
`timescale 1ns / 1ps
interface wpf_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [24:0] vel_x;
  logic signed [24:0] vel_y;
  logic [4:0]  target_index;
  logic        finished;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, target_index, finished,
                  input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, target_index, finished,
                output ready);
endinterface

// File: rtl/wpf_ctrl.sv
`timescale 1ns / 1ps
module wpf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wpf_pkg::status_t status_i,
  output wpf_pkg::cmd_t    cmd_o
);

  wpf_pkg::state_e state_q, state_d;
  logic [wpf_pkg::STEP_W-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpf_pkg::S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  localparam logic [wpf_pkg::STEP_W-1:0] LastStep = wpf_pkg::STEP_W'(wpf_pkg::STEPS - 1);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = wpf_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    case (state_q)
      wpf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = wpf_pkg::OP_CAPTURE;
          state_d  = wpf_pkg::S_DISPATCH;
        end
      end
      wpf_pkg::S_DISPATCH: begin
        case (status_i.mode)
          wpf_pkg::MODE_LOAD: begin
            cmd_o.op = wpf_pkg::OP_LOAD;
            state_d  = wpf_pkg::S_PUB;
          end
          wpf_pkg::MODE_START: state_d = wpf_pkg::S_START_RD;
          wpf_pkg::MODE_TICK: begin
            if (status_i.done) begin
              state_d = wpf_pkg::S_PUB;
            end else if (status_i.tgt_bad) begin
              cmd_o.op = wpf_pkg::OP_FINISH;
              state_d  = wpf_pkg::S_PUB;
            end else begin
              state_d = wpf_pkg::S_TK_PREV;
            end
          end
          default: state_d = wpf_pkg::S_PUB;
        endcase
      end
      wpf_pkg::S_START_RD: begin
        cmd_o.op = wpf_pkg::OP_RD_ZERO;
        state_d  = wpf_pkg::S_START_SET;
      end
      wpf_pkg::S_START_SET: begin
        cmd_o.op = wpf_pkg::OP_START;
        state_d  = wpf_pkg::S_PUB;
      end
      wpf_pkg::S_TK_PREV: begin
        cmd_o.op = wpf_pkg::OP_RD_PREV;
        state_d  = wpf_pkg::S_TK_TGT;
      end
      wpf_pkg::S_TK_TGT: begin
        cmd_o.op = wpf_pkg::OP_RD_TGT;
        state_d  = wpf_pkg::S_TK_DIR;
      end
      wpf_pkg::S_TK_DIR: begin
        cmd_o.op = wpf_pkg::OP_DIR;
        state_d  = wpf_pkg::S_SQX;
      end
      wpf_pkg::S_SQX: begin
        cmd_o.op = wpf_pkg::OP_SQX;
        state_d  = wpf_pkg::S_SQY;
      end
      wpf_pkg::S_SQY: begin
        cmd_o.op = wpf_pkg::OP_SQY;
        state_d  = wpf_pkg::S_SQSUM;
      end
      wpf_pkg::S_SQSUM: begin
        cmd_o.op = wpf_pkg::OP_SQSUM;
        step_d   = '0;
        state_d  = wpf_pkg::S_SQRT;
      end
      wpf_pkg::S_SQRT: begin
        cmd_o.op = wpf_pkg::OP_SQRT_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == LastStep) state_d = wpf_pkg::S_NUMX;
      end
      wpf_pkg::S_NUMX: begin
        cmd_o.op = wpf_pkg::OP_NUMX;
        state_d  = wpf_pkg::S_NUMY;
      end
      wpf_pkg::S_NUMY: begin
        cmd_o.op = wpf_pkg::OP_NUMY;
        state_d  = wpf_pkg::S_DIVSET;
      end
      wpf_pkg::S_DIVSET: begin
        cmd_o.op = wpf_pkg::OP_DIVSET;
        step_d   = '0;
        state_d  = wpf_pkg::S_DIV;
      end
      wpf_pkg::S_DIV: begin
        cmd_o.op = wpf_pkg::OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == LastStep) state_d = wpf_pkg::S_VEL;
      end
      wpf_pkg::S_VEL: begin
        cmd_o.op = wpf_pkg::OP_VEL;
        state_d  = wpf_pkg::S_DISPX;
      end
      wpf_pkg::S_DISPX: begin
        cmd_o.op = wpf_pkg::OP_DISPX;
        state_d  = wpf_pkg::S_DISPY;
      end
      wpf_pkg::S_DISPY: begin
        cmd_o.op = wpf_pkg::OP_DISPY;
        state_d  = wpf_pkg::S_DOTX;
      end
      wpf_pkg::S_DOTX: begin
        cmd_o.op = wpf_pkg::OP_DOTX;
        state_d  = wpf_pkg::S_DOTY;
      end
      wpf_pkg::S_DOTY: begin
        cmd_o.op = wpf_pkg::OP_DOTY;
        state_d  = wpf_pkg::S_UPD;
      end
      wpf_pkg::S_UPD: begin
        cmd_o.op = wpf_pkg::OP_UPDATE;
        state_d  = wpf_pkg::S_PUB;
      end
      wpf_pkg::S_PUB: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = wpf_pkg::OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = wpf_pkg::S_IDLE;
        end
      end
      default: state_d = wpf_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/wpf_dpath.sv
`timescale 1ns / 1ps
module wpf_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wpf_pkg::cmd_t                cmd_i,
  output wpf_pkg::status_t             status_o,
  input  logic [wpf_pkg::SPEED_W-1:0]  speed_i,
  input  logic [wpf_pkg::TGT_W-1:0]    count_i,
  input  logic [1:0]                   mode_i,
  input  logic [3:0]                   point_index_i,
  input  logic signed [23:0]           point_x_i,
  input  logic signed [23:0]           point_y_i,
  input  logic [15:0]                  time_step_i,
  output logic signed [23:0]           pos_x_o,
  output logic signed [23:0]           pos_y_o,
  output logic signed [24:0]           vel_x_o,
  output logic signed [24:0]           vel_y_o,
  output logic [4:0]                   target_index_o,
  output logic                         finished_o
);

  localparam int unsigned PW = wpf_pkg::POS_W;
  localparam int unsigned MW = wpf_pkg::MAG_W;
  localparam int unsigned RW = wpf_pkg::RAD_W;
  localparam int unsigned QW = wpf_pkg::Q_W;
  localparam int unsigned NW = wpf_pkg::NUM_W;
  localparam int unsigned UW = wpf_pkg::MUL_W;
  localparam int unsigned XW = wpf_pkg::PROD_W;
  localparam int unsigned IW = wpf_pkg::IDX_W;

  localparam logic signed [PW+2:0] PosMax = (PW+3)'((1 << (PW - 1)) - 1);
  localparam logic signed [PW+2:0] PosMin = -(PW+3)'(1 << (PW - 1));

  // item
  logic [1:0]          mode_q;
  logic [3:0]          idx_q;
  logic signed [PW-1:0] px_q, py_q;
  logic [15:0]         dt_q;

  // waypoint memory
  logic [2*PW-1:0] wp_mem [wpf_pkg::MAX_POINTS];
  logic [2*PW-1:0] rd_q;
  logic [IW-1:0]   rd_addr;

  // architectural state
  logic signed [PW-1:0]   pos_x_q, pos_y_q;
  logic signed [QW-1:0]   vel_x_q, vel_y_q;
  logic [wpf_pkg::TGT_W-1:0] tgt_q;
  logic                   done_q;

  // working registers
  logic signed [PW-1:0] prev_x_q, prev_y_q, wt_x_q, wt_y_q;
  logic [MW-1:0]        mx_q, my_q;
  logic                 nx_q, ny_q;
  logic signed [XW-1:0] prod_q;
  logic [RW-1:0]        sq_q, rad_q;
  logic [MW:0]          srem_q;
  logic [MW-1:0]        root_q;
  logic [MW-1:0]        drx_q, dry_q, dsx_q, dsy_q;
  logic [QW-1:0]        qx_q, qy_q;
  logic signed [QW:0]   sx_q, sy_q;
  logic signed [XW:0]   dot_q;

  // output payload
  logic signed [PW-1:0] o_px_q, o_py_q;
  logic signed [QW-1:0] o_vx_q, o_vy_q;
  logic [wpf_pkg::TGT_W-1:0] o_tgt_q;
  logic o_fin_q;

  // shared multiplier
  logic signed [UW-1:0] mul_a, mul_b;
  logic signed [XW-1:0] mul_p;

  logic [wpf_pkg::TGT_W-1:0] cnt_eff;
  logic signed [MW-1:0] dx, dy;
  logic [MW+2:0] s_cat, s_trial;
  logic [MW:0] dx_cat, dy_cat;
  logic [NW-1:0] num;
  logic [QW-1:0] vmag_x, vmag_y;
  logic signed [QW:0] disp;
  logic signed [XW:0] dot_sum;
  logic signed [PW+2:0] sum_x, sum_y;
  logic [wpf_pkg::TGT_W-1:0] tgt_inc;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW+2:0] v);
    if (v > PosMax) return PosMax[PW-1:0];
    if (v < PosMin) return PosMin[PW-1:0];
    return v[PW-1:0];
  endfunction

  always_comb begin
    if (count_i < 5'd2) cnt_eff = 5'd2;
    else if (count_i > wpf_pkg::TGT_W'(wpf_pkg::MAX_POINTS))
      cnt_eff = wpf_pkg::TGT_W'(wpf_pkg::MAX_POINTS);
    else cnt_eff = count_i;
  end

  assign status_o.mode    = mode_q;
  assign status_o.done    = done_q;
  assign status_o.tgt_bad = (tgt_q >= cnt_eff) || (tgt_q == '0);

  always_comb begin
    case (cmd_i.op)
      wpf_pkg::OP_RD_PREV: rd_addr = IW'(tgt_q - 1'b1);
      wpf_pkg::OP_RD_TGT:  rd_addr = tgt_q[IW-1:0];
      default:             rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wpf_pkg::OP_LOAD) wp_mem[idx_q[IW-1:0]] <= {px_q, py_q};
    rd_q <= wp_mem[rd_addr];
  end

  assign dx = MW'(signed'(rd_q[2*PW-1:PW])) - MW'(prev_x_q);
  assign dy = MW'(signed'(rd_q[PW-1:0])) - MW'(prev_y_q);

  assign vmag_x = vel_x_q[QW-1] ? QW'(-vel_x_q) : QW'(vel_x_q);
  assign vmag_y = vel_y_q[QW-1] ? QW'(-vel_y_q) : QW'(vel_y_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      wpf_pkg::OP_SQX: begin
        mul_a = signed'(UW'(mx_q));
        mul_b = signed'(UW'(mx_q));
      end
      wpf_pkg::OP_SQY: begin
        mul_a = signed'(UW'(my_q));
        mul_b = signed'(UW'(my_q));
      end
      wpf_pkg::OP_NUMX: begin
        mul_a = signed'(UW'(mx_q));
        mul_b = signed'(UW'(speed_i));
      end
      wpf_pkg::OP_NUMY: begin
        mul_a = signed'(UW'(my_q));
        mul_b = signed'(UW'(speed_i));
      end
      wpf_pkg::OP_DISPX: begin
        mul_a = signed'(UW'(vmag_x));
        mul_b = signed'(UW'(dt_q));
      end
      wpf_pkg::OP_DISPY: begin
        mul_a = signed'(UW'(vmag_y));
        mul_b = signed'(UW'(dt_q));
      end
      wpf_pkg::OP_DOTX: begin
        mul_a = UW'(MW'(wt_x_q) - MW'(pos_x_q));
        mul_b = UW'(sx_q);
      end
      wpf_pkg::OP_DOTY: begin
        mul_a = UW'(MW'(wt_y_q) - MW'(pos_y_q));
        mul_b = UW'(disp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product of the previous cycle as numerator or as a signed displacement; during OP_DOTY disp is sy_q
  assign num  = NW'({prod_q[NW-wpf_pkg::FRAC_BITS-1:0], {wpf_pkg::FRAC_BITS{1'b0}}});
  assign disp = (cmd_i.op == wpf_pkg::OP_DOTY)
              ? sy_q
              : ((cmd_i.op == wpf_pkg::OP_DISPY) ? (nx_q ? -$signed({1'b0, prod_q[16 +: QW]})
                                                           :  $signed({1'b0, prod_q[16 +: QW]}))
                                                 : (ny_q ? -$signed({1'b0, prod_q[16 +: QW]})
                                                         :  $signed({1'b0, prod_q[16 +: QW]})));

  assign s_cat   = {srem_q, rad_q[RW-1 -: 2]};
  assign s_trial = {1'b0, root_q, 2'b01};
  assign dx_cat  = {drx_q, dsx_q[MW-1]};
  assign dy_cat  = {dry_q, dsy_q[MW-1]};
  assign dot_sum = dot_q + (XW+1)'(prod_q);
  assign sum_x   = (PW+3)'(pos_x_q) + (PW+3)'(sx_q);
  assign sum_y   = (PW+3)'(pos_y_q) + (PW+3)'(sy_q);
  assign tgt_inc = tgt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      tgt_q   <= 5'd1;
      done_q  <= 1'b1;
    end else begin
      case (cmd_i.op)
        wpf_pkg::OP_START: begin
          pos_x_q <= signed'(rd_q[2*PW-1:PW]);
          pos_y_q <= signed'(rd_q[PW-1:0]);
          vel_x_q <= '0;
          vel_y_q <= '0;
          tgt_q   <= 5'd1;
          done_q  <= 1'b0;
        end
        wpf_pkg::OP_FINISH: done_q <= 1'b1;
        wpf_pkg::OP_VEL: begin
          if (root_q == '0) begin
            vel_x_q <= '0;
            vel_y_q <= '0;
          end else begin
            vel_x_q <= nx_q ? -signed'(qx_q) : signed'(qx_q);
            vel_y_q <= ny_q ? -signed'(qy_q) : signed'(qy_q);
          end
        end
        wpf_pkg::OP_UPDATE: begin
          if (dot_sum < 0) begin
            tgt_q <= tgt_inc;
            if (tgt_inc >= cnt_eff) done_q <= 1'b1;
          end
          pos_x_q <= sat_pos(sum_x);
          pos_y_q <= sat_pos(sum_y);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      wpf_pkg::OP_CAPTURE: begin
        mode_q <= mode_i;
        idx_q  <= point_index_i;
        px_q   <= point_x_i;
        py_q   <= point_y_i;
        dt_q   <= time_step_i;
      end
      wpf_pkg::OP_RD_TGT: begin
        prev_x_q <= signed'(rd_q[2*PW-1:PW]);
        prev_y_q <= signed'(rd_q[PW-1:0]);
      end
      wpf_pkg::OP_DIR: begin
        wt_x_q <= signed'(rd_q[2*PW-1:PW]);
        wt_y_q <= signed'(rd_q[PW-1:0]);
        nx_q   <= dx[MW-1];
        ny_q   <= dy[MW-1];
        mx_q   <= dx[MW-1] ? MW'(-dx) : MW'(dx);
        my_q   <= dy[MW-1] ? MW'(-dy) : MW'(dy);
      end
      wpf_pkg::OP_SQX: prod_q <= mul_p;
      wpf_pkg::OP_SQY: begin
        sq_q   <= RW'(prod_q);
        prod_q <= mul_p;
      end
      wpf_pkg::OP_SQSUM: begin
        rad_q  <= sq_q + RW'(prod_q);
        srem_q <= '0;
        root_q <= '0;
      end
      wpf_pkg::OP_SQRT_STEP: begin
        rad_q <= rad_q << 2;
        if (s_cat >= s_trial) begin
          srem_q <= (MW+1)'(s_cat - s_trial);
          root_q <= {root_q[MW-2:0], 1'b1};
        end else begin
          srem_q <= s_cat[MW:0];
          root_q <= {root_q[MW-2:0], 1'b0};
        end
      end
      wpf_pkg::OP_NUMX: prod_q <= mul_p;
      wpf_pkg::OP_NUMY: begin
        drx_q  <= MW'(num[NW-1:QW]);
        dsx_q  <= num[QW-1:0];
        prod_q <= mul_p;
      end
      wpf_pkg::OP_DIVSET: begin
        dry_q <= MW'(num[NW-1:QW]);
        dsy_q <= num[QW-1:0];
      end
      wpf_pkg::OP_DIV_STEP: begin
        dsx_q <= dsx_q << 1;
        dsy_q <= dsy_q << 1;
        if (dx_cat >= (MW+1)'(root_q)) begin
          drx_q <= MW'(dx_cat - (MW+1)'(root_q));
          qx_q  <= {qx_q[QW-2:0], 1'b1};
        end else begin
          drx_q <= MW'(dx_cat);
          qx_q  <= {qx_q[QW-2:0], 1'b0};
        end
        if (dy_cat >= (MW+1)'(root_q)) begin
          dry_q <= MW'(dy_cat - (MW+1)'(root_q));
          qy_q  <= {qy_q[QW-2:0], 1'b1};
        end else begin
          dry_q <= MW'(dy_cat);
          qy_q  <= {qy_q[QW-2:0], 1'b0};
        end
      end
      wpf_pkg::OP_DISPX: prod_q <= mul_p;
      wpf_pkg::OP_DISPY: begin
        sx_q   <= disp;
        prod_q <= mul_p;
      end
      wpf_pkg::OP_DOTX: begin
        sy_q   <= disp;
        prod_q <= mul_p;
      end
      wpf_pkg::OP_DOTY: begin
        dot_q  <= (XW+1)'(prod_q);
        prod_q <= mul_p;
      end
      wpf_pkg::OP_PUBLISH: begin
        o_px_q  <= pos_x_q;
        o_py_q  <= pos_y_q;
        o_vx_q  <= vel_x_q;
        o_vy_q  <= vel_y_q;
        o_tgt_q <= tgt_q;
        o_fin_q <= done_q;
      end
      default: ;
    endcase
  end

  assign pos_x_o        = o_px_q;
  assign pos_y_o        = o_py_q;
  assign vel_x_o        = o_vx_q;
  assign vel_y_o        = o_vy_q;
  assign target_index_o = o_tgt_q;
  assign finished_o     = o_fin_q;

endmodule

// File: rtl/waypoint_path_follower_core.sv
`timescale 1ns / 1ps
// Waypoint path follower.
// in_s  : request channel (valid/ready). mode load writes a waypoint slot,
//         mode start places the position on waypoint 0 heading for waypoint 1,
//         mode tick advances the position by one time step unless the path is finished.
// out_s : one result per request: position, velocity, target index and
//         finished flag as they stand after the request.
// APB   : register 0 speed (addr 0), register 1 point count (addr 4);
//         pready is always high; the user must write only while the block is idle,
//         which the block itself does not enforce.
// Load, finishing and ignored requests go straight to the result; a tick that
//   moves first runs the bit-serial square root (25 steps), then the two
//   parallel bit-serial dividers (25 steps). One request is in work at a time;
//   the next one is accepted once the previous result is in the output register.
// Reset: position and velocity zero, target 1, finished set, speed 100,
//   point count 2. Waypoint slots hold nothing until loaded.
// When the receiver stalls the result stays in the output register and
//   the next computed result waits in the datapath until the old one is taken.
module waypoint_path_follower_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpf_in_if.sink      in_s,
  wpf_out_if.source   out_s,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [wpf_pkg::SPEED_W-1:0] speed_q;
  logic [wpf_pkg::TGT_W-1:0]   count_q;
  logic                        wr_en;
  wpf_pkg::cmd_t               cmd;
  wpf_pkg::status_t            status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= wpf_pkg::SPEED_RST;
      count_q <= wpf_pkg::COUNT_RST;
    end else if (wr_en) begin
      if (paddr[2] == wpf_pkg::REG_SPEED) speed_q <= pwdata[wpf_pkg::SPEED_W-1:0];
      else count_q <= pwdata[wpf_pkg::TGT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == wpf_pkg::REG_SPEED) ? 32'(speed_q) : 32'(count_q);

  wpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wpf_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .speed_i        (speed_q),
    .count_i        (count_q),
    .mode_i         (in_s.mode),
    .point_index_i  (in_s.point_index),
    .point_x_i      (in_s.point_x),
    .point_y_i      (in_s.point_y),
    .time_step_i    (in_s.time_step),
    .pos_x_o        (out_s.pos_x),
    .pos_y_o        (out_s.pos_y),
    .vel_x_o        (out_s.vel_x),
    .vel_y_o        (out_s.vel_y),
    .target_index_o (out_s.target_index),
    .finished_o     (out_s.finished)
  );

endmodule

// File: rtl/wpf_checker.sv
`timescale 1ns / 1ps
module wpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pos_x,
  input logic [4:0]  target_index
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in work");

  a_target_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> target_index != 5'd0)
    else $error("result shows target index zero");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(pos_x))
    else $error("result changed while stalled");

endmodule

bind waypoint_path_follower_core wpf_checker u_wpf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_s.valid),
  .in_ready     (in_s.ready),
  .out_valid    (out_s.valid),
  .out_ready    (out_s.ready),
  .pos_x        (out_s.pos_x),
  .target_index (out_s.target_index)
);
